[design/mcr_pkg.sv]
package mcr_pkg;

    // Coordinate widths
    localparam int COORD_BITS = 10;
    localparam int IN_BITS    = 9;
    localparam int DIFF_BITS  = IN_BITS + 1;
    localparam int SQ_BITS    = 2 * DIFF_BITS;
    localparam int ROOT_BITS  = SQ_BITS / 2;
    localparam int STEP_BITS  = COORD_BITS + 2;
    localparam int DEC_BITS   = COORD_BITS + 4;
    localparam int PIX_BITS   = 11;
    localparam int SUM_BITS   = ((STEP_BITS > IN_BITS) ? STEP_BITS : IN_BITS) + 1;
    localparam int RMAX       = (1 << COORD_BITS) - 1;

    // Pixel group
    localparam int GROUP_SIZE = 8;
    localparam int K_BITS     = $clog2(GROUP_SIZE);
    localparam logic [K_BITS-1:0] K_LAST = K_BITS'(GROUP_SIZE - 1);

    // Decision term constants
    localparam int DEC_INIT       = 3;
    localparam int DEC_STEP_DIAG  = 10;
    localparam int DEC_STEP_AXIAL = 6;

    // Input action codes
    localparam logic ACT_START   = 1'b0;
    localparam logic ACT_ADVANCE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_X,
        S_MUL_Y,
        S_SQRT_GO,
        S_SQRT_WAIT,
        S_EMIT
    } t_state;

    // Current circle position handed to the pixel unit
    typedef struct packed {
        logic signed [IN_BITS-1:0]   cx;
        logic signed [IN_BITS-1:0]   cy;
        logic signed [STEP_BITS-1:0] x;
        logic signed [STEP_BITS-1:0] y;
    } t_geom;

endpackage

[design/mcr_isqrt.sv]
module mcr_isqrt (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [mcr_pkg::SQ_BITS-1:0]    i_radicand,
    output logic                           o_done,
    output logic [mcr_pkg::ROOT_BITS-1:0]  o_root
);
    import mcr_pkg::*;

    logic               r_busy;
    logic               r_done;
    logic [SQ_BITS-1:0] r_rem;
    logic [SQ_BITS-1:0] r_root;
    logic [SQ_BITS-1:0] r_bit;
    logic [SQ_BITS-1:0] trial;
    logic               fits;

    // One result bit per cycle: trial subtract of root + bit
    assign trial = r_root + r_bit;
    assign fits  = (r_rem >= trial);

    // Control: busy over one pass of the bit marker, done pulses at the end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath: remainder, partial root and bit marker
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_radicand;
            r_root <= '0;
            r_bit  <= SQ_BITS'(1) << (SQ_BITS - 2);
        end else if (r_busy) begin
            if (fits) begin
                r_rem  <= r_rem - trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root[ROOT_BITS-1:0];

endmodule

[design/mcr_pixgen.sv]
module mcr_pixgen (
    input  mcr_pkg::t_geom                        i_geom,
    input  logic [mcr_pkg::K_BITS-1:0]            i_k,
    output logic signed [mcr_pkg::PIX_BITS-1:0]   o_pixel_x,
    output logic signed [mcr_pkg::PIX_BITS-1:0]   o_pixel_y
);
    import mcr_pkg::*;

    logic signed [STEP_BITS-1:0] off_x;
    logic signed [STEP_BITS-1:0] off_y;
    logic signed [SUM_BITS-1:0]  ext_x;
    logic signed [SUM_BITS-1:0]  ext_y;
    logic signed [SUM_BITS-1:0]  sum_x;
    logic signed [SUM_BITS-1:0]  sum_y;

    // Pick octant: upper index bit swaps x and y, low bits negate each offset
    always_comb begin
        off_x = i_k[2] ? i_geom.y : i_geom.x;
        off_y = i_k[2] ? i_geom.x : i_geom.y;
        ext_x = SUM_BITS'(off_x);
        ext_y = SUM_BITS'(off_y);
        sum_x = i_k[0] ? (SUM_BITS'(i_geom.cx) - ext_x) : (SUM_BITS'(i_geom.cx) + ext_x);
        sum_y = i_k[1] ? (SUM_BITS'(i_geom.cy) - ext_y) : (SUM_BITS'(i_geom.cy) + ext_y);
    end

    // Wrap to the pixel width
    assign o_pixel_x = PIX_BITS'(sum_x);
    assign o_pixel_y = PIX_BITS'(sum_y);

endmodule

[design/midpoint_circle_rasterizer.sv]
// Midpoint circle rasterizer. A start item (action 0) takes a centre and a
// point on the edge; the radius is the floor of the square root of the
// squared distance. The block squares both deltas on one multiplier, runs a
// radix-4 square root one bit per cycle, then emits the eight symmetric
// pixels of the first group through an output register, one per cycle
// while the output is not stalled. An advance item (action 1) runs one
// midpoint step and emits the next group of eight pixels in the same way.
// An advance with no circle in progress emits nothing. o_last marks the
// eighth pixel of each group; o_circle_done marks every pixel of the
// final group, the one in which y has dropped below x. Input is stalled
// while an item is being worked on.
module midpoint_circle_rasterizer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_action,
    input  logic signed [mcr_pkg::IN_BITS-1:0]   i_center_x,
    input  logic signed [mcr_pkg::IN_BITS-1:0]   i_center_y,
    input  logic signed [mcr_pkg::IN_BITS-1:0]   i_edge_x,
    input  logic signed [mcr_pkg::IN_BITS-1:0]   i_edge_y,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [mcr_pkg::PIX_BITS-1:0]  o_pixel_x,
    output logic signed [mcr_pkg::PIX_BITS-1:0]  o_pixel_y,
    output logic                                 o_last,
    output logic                                 o_circle_done
);
    import mcr_pkg::*;

    t_state r_state;
    t_state n_state;

    logic signed [IN_BITS-1:0]   r_cx;
    logic signed [IN_BITS-1:0]   r_cy;
    logic signed [DIFF_BITS-1:0] r_dx;
    logic signed [DIFF_BITS-1:0] r_dy;
    logic [SQ_BITS-1:0]          r_sq;
    logic signed [STEP_BITS-1:0] r_x;
    logic signed [STEP_BITS-1:0] r_y;
    logic signed [DEC_BITS-1:0]  r_dec;
    logic                        r_active;
    logic [K_BITS-1:0]           r_k;
    logic                        r_out_valid;
    logic signed [PIX_BITS-1:0]  r_pix_x;
    logic signed [PIX_BITS-1:0]  r_pix_y;
    logic                        r_last;
    logic                        r_done;

    logic                        in_xfer;
    logic                        is_start;
    logic                        sqrt_start;
    logic                        sqrt_done;
    logic [ROOT_BITS-1:0]        sqrt_root;
    logic                        pix_load;
    logic                        in_stall;

    logic signed [DIFF_BITS-1:0] mul_op;
    logic signed [SQ_BITS-1:0]   prod;
    logic [SQ_BITS-1:0]          sq_sum;

    logic [STEP_BITS-1:0]        root_sat;
    logic signed [DEC_BITS-1:0]  dec_init;
    logic                        dec_pos;
    logic signed [STEP_BITS-1:0] x_inc;
    logic signed [STEP_BITS-1:0] y_next;
    logic signed [DEC_BITS-1:0]  dec_next;

    logic signed [PIX_BITS-1:0]  gen_x;
    logic signed [PIX_BITS-1:0]  gen_y;
    t_geom                       geom;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign is_start = (i_action == ACT_START);

    // Shared multiplier: squares dx, then dy
    assign mul_op = (r_state == S_MUL_X) ? r_dx : r_dy;
    assign prod   = SQ_BITS'(mul_op) * SQ_BITS'(mul_op);
    assign sq_sum = r_sq + SQ_BITS'(prod);

    // Clamp radius and form the initial decision term
    always_comb begin
        if (32'(sqrt_root) > 32'(RMAX)) begin
            root_sat = STEP_BITS'(RMAX);
        end else begin
            root_sat = STEP_BITS'(sqrt_root);
        end
        dec_init = DEC_BITS'(DEC_INIT) - (DEC_BITS'(root_sat) <<< 1);
    end

    // One midpoint step
    always_comb begin
        dec_pos = !r_dec[DEC_BITS-1] && (r_dec != '0);
        x_inc   = r_x + STEP_BITS'(1);
        y_next  = dec_pos ? (r_y - STEP_BITS'(1)) : r_y;
        if (dec_pos) begin
            dec_next = r_dec + ((DEC_BITS'(x_inc) - DEC_BITS'(y_next)) <<< 2)
                       + DEC_BITS'(DEC_STEP_DIAG);
        end else begin
            dec_next = r_dec + (DEC_BITS'(x_inc) <<< 2) + DEC_BITS'(DEC_STEP_AXIAL);
        end
    end

    mcr_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (r_sq),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root)
    );

    assign geom = '{cx: r_cx, cy: r_cy, x: r_x, y: r_y};

    mcr_pixgen u_pixgen (
        .i_geom    (geom),
        .i_k       (r_k),
        .o_pixel_x (gen_x),
        .o_pixel_y (gen_y)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (is_start) begin
                        n_state = S_MUL_X;
                    end else if (r_active) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_MUL_X:     n_state = S_MUL_Y;
            S_MUL_Y:     n_state = S_SQRT_GO;
            S_SQRT_GO:   n_state = S_SQRT_WAIT;
            S_SQRT_WAIT: begin
                if (sqrt_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (pix_load && (r_k == K_LAST)) begin
                    n_state = S_IDLE;
                end
            end
            default:     n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        in_stall   = 1'b1;
        sqrt_start = 1'b0;
        pix_load   = 1'b0;
        unique case (r_state)
            S_IDLE:      in_stall   = 1'b0;
            S_SQRT_GO:   sqrt_start = 1'b1;
            S_EMIT:      pix_load   = !r_out_valid || !i_out_stall;
            S_MUL_X, S_MUL_Y, S_SQRT_WAIT: ;
            default:     in_stall   = 1'b1;
        endcase
    end

    assign o_in_stall = in_stall;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_IDLE) && in_xfer && !is_start && r_active) begin
                r_active <= (y_next >= x_inc);
            end else if ((r_state == S_SQRT_WAIT) && sqrt_done) begin
                r_active <= 1'b1;
            end
            if (pix_load) begin
                r_k <= r_k + K_BITS'(1);
            end
            if (pix_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Circle datapath
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && in_xfer) begin
            if (is_start) begin
                r_cx <= i_center_x;
                r_cy <= i_center_y;
                r_dx <= DIFF_BITS'(i_center_x) - DIFF_BITS'(i_edge_x);
                r_dy <= DIFF_BITS'(i_center_y) - DIFF_BITS'(i_edge_y);
            end else if (r_active) begin
                r_x   <= x_inc;
                r_y   <= y_next;
                r_dec <= dec_next;
            end
        end
        if (r_state == S_MUL_X) begin
            r_sq <= SQ_BITS'(prod);
        end else if (r_state == S_MUL_Y) begin
            r_sq <= sq_sum;
        end
        if ((r_state == S_SQRT_WAIT) && sqrt_done) begin
            r_x   <= '0;
            r_y   <= root_sat;
            r_dec <= dec_init;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (pix_load) begin
            r_pix_x <= gen_x;
            r_pix_y <= gen_y;
            r_last  <= (r_k == K_LAST);
            r_done  <= !r_active;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_x     = r_pix_x;
    assign o_pixel_y     = r_pix_y;
    assign o_last        = r_last;
    assign o_circle_done = r_done;

endmodule

[design/mcr_checker.sv]
module mcr_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 o_in_stall,
    input  logic                                 i_action,
    input  logic signed [mcr_pkg::IN_BITS-1:0]   i_center_x,
    input  logic signed [mcr_pkg::IN_BITS-1:0]   i_center_y,
    input  logic signed [mcr_pkg::IN_BITS-1:0]   i_edge_x,
    input  logic signed [mcr_pkg::IN_BITS-1:0]   i_edge_y,
    input  logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    input  logic signed [mcr_pkg::PIX_BITS-1:0]  o_pixel_x,
    input  logic signed [mcr_pkg::PIX_BITS-1:0]  o_pixel_y,
    input  logic                                 o_last,
    input  logic                                 o_circle_done
);
    import mcr_pkg::*;

    logic in_xfer;
    logic out_xfer;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_xfer = o_out_valid && !i_out_stall;

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A start always occupies the block for the following cycle
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (i_action == ACT_START)) |=> o_in_stall)
        else $error("input taken right after a start");

    // No new item while a pixel group is still incomplete
    a_group_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && !o_last) |-> o_in_stall)
        else $error("input taken in the middle of a pixel group");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_pixel_x) && $stable(o_pixel_y)
             && $stable(o_last) && $stable(o_circle_done)))
        else $error("stalled output changed");

endmodule

bind midpoint_circle_rasterizer mcr_checker u_mcr_checker (.*);
